/* rtl/lpm_pkg.sv */
// Shared constants and types of the IPv4 longest-prefix route lookup.
package lpm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_BITS   = 32;
	localparam int IFACE_W     = 4;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic REG_ENTRIES_IN_USE = 1'b0;

	typedef struct packed {
		logic [ADDR_BITS-1:0] prefix;
		logic [ADDR_BITS-1:0] mask;
		logic [ADDR_BITS-1:0] gateway;
		logic [IFACE_W-1:0]   iface;
	} lpm_entry_t;

	localparam int ENTRY_W = $bits(lpm_entry_t);

endpackage

/* rtl/lpm_if.sv */
// Valid/ready channel interfaces for lookup requests and results.
interface lpm_in_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [5:0]                      entry_index;
	logic [lpm_pkg::ADDR_BITS-1:0]   entry_prefix;
	logic [lpm_pkg::ADDR_BITS-1:0]   entry_mask;
	logic [lpm_pkg::ADDR_BITS-1:0]   entry_next_hop;
	logic [lpm_pkg::IFACE_W-1:0]     entry_interface;
	logic [lpm_pkg::ADDR_BITS-1:0]   dest_addr;

	modport source (output valid, command, entry_index, entry_prefix, entry_mask,
		entry_next_hop, entry_interface, dest_addr, input ready);
	modport sink (input valid, command, entry_index, entry_prefix, entry_mask,
		entry_next_hop, entry_interface, dest_addr, output ready);
endinterface

interface lpm_out_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [5:0]                      match_index;
	logic [lpm_pkg::ADDR_BITS-1:0]   next_hop_addr;
	logic [lpm_pkg::IFACE_W-1:0]     out_interface;

	modport source (output valid, found, match_index, next_hop_addr, out_interface,
		input ready);
	modport sink (input valid, found, match_index, next_hop_addr, out_interface,
		output ready);
endinterface

/* rtl/lpm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/ipv4_longest_prefix_route_lookup_unit.sv */
// Top level of the IPv4 longest-prefix route lookup with its routing table RAM.
//
// Requests arrive on in_ch and results leave on out_ch, both valid/ready; a
// transaction completes when valid and ready are high at a clock edge. Each
// request gives exactly one result, in order. A load request writes one table
// entry and goes straight to the done state, from which an all-zero result
// is written to the output register. A lookup reads one table entry per
// cycle from the single read port of the table RAM, min(entries_in_use, 64)
// entries in all, and its result then goes from the done state to the
// output register; with no entry in use it skips the scan. One request is
// worked on at a time; a new one is taken while the previous result still
// waits in the output register. When the receiver stalls, the finished result
// holds in the output register, one further request is worked on and then
// waits, and input is refused until the stalled result is taken.
// entries_in_use is written through the APB port at byte address 0 and reads
// back there. Reset clears the control state, the output valid flag and
// entries_in_use; the table contents are undefined until loaded, and a lookup
// must only scan entries that have been loaded.
module ipv4_longest_prefix_route_lookup_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	lpm_in_if.sink                        in_ch,
	lpm_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpm_pkg::PADDR_W-1:0]   paddr,
	input  logic [lpm_pkg::PDATA_W-1:0]   pwdata,
	output logic [lpm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                         state_q;
	logic [lpm_pkg::CNT_W-1:0]          entries_q;
	logic [lpm_pkg::CNT_W-1:0]          cnt_q;
	logic [lpm_pkg::CNT_W-1:0]          limit_q;
	logic [lpm_pkg::CNT_W-1:0]          limit_next;
	logic [lpm_pkg::ADDR_BITS-1:0]      dest_q;
	logic                               rd_valid_s1;
	logic [lpm_pkg::IDX_W-1:0]          rd_idx_s1;
	logic                               have_q;
	logic [lpm_pkg::IDX_W-1:0]          best_idx_q;
	logic [lpm_pkg::ADDR_BITS-1:0]      best_mask_q;
	logic [lpm_pkg::ADDR_BITS-1:0]      best_gateway_q;
	logic [lpm_pkg::IFACE_W-1:0]        best_iface_q;
	logic                               out_valid_q;
	logic                               found_q;
	logic [lpm_pkg::IDX_W-1:0]          match_index_q;
	logic [lpm_pkg::ADDR_BITS-1:0]      gateway_q;
	logic [lpm_pkg::IFACE_W-1:0]        iface_q;
	logic                               in_acc;
	logic                               out_free;
	logic                               issue;
	logic                               ram_we;
	logic                               cfg_wr;
	logic                               hit;
	logic                               better;
	lpm_pkg::lpm_entry_t                wr_entry;
	lpm_pkg::lpm_entry_t                rd_entry;
	logic [lpm_pkg::ENTRY_W-1:0]        rdata;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready &&
		(paddr[lpm_pkg::PADDR_W-1] == lpm_pkg::REG_ENTRIES_IN_USE);
	assign prdata   = (paddr[lpm_pkg::PADDR_W-1] == lpm_pkg::REG_ENTRIES_IN_USE) ?
		{{(lpm_pkg::PDATA_W-lpm_pkg::CNT_W){1'b0}}, entries_q} : '0;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign issue       = (state_q == ST_SCAN) && (cnt_q < limit_q);
	assign ram_we      = in_acc && (in_ch.command == lpm_pkg::CMD_LOAD);
	assign limit_next  = (entries_q > lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH)) ?
		lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH) : entries_q;

	assign wr_entry.prefix   = in_ch.entry_prefix;
	assign wr_entry.mask     = in_ch.entry_mask;
	assign wr_entry.gateway  = in_ch.entry_next_hop;
	assign wr_entry.iface    = in_ch.entry_interface;
	assign rd_entry          = lpm_pkg::lpm_entry_t'(rdata);

	assign hit    = rd_valid_s1 && ((dest_q & rd_entry.mask) == rd_entry.prefix);
	assign better = !have_q || (best_mask_q < rd_entry.mask);

	lpm_ram #(
		.WIDTH(lpm_pkg::ENTRY_W),
		.DEPTH(lpm_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_ch.entry_index[lpm_pkg::IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (cnt_q[lpm_pkg::IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entries_q   <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				entries_q <= pwdata[lpm_pkg::CNT_W-1:0];
			end
			rd_valid_s1 <= issue;
			if (hit && better) begin
				have_q <= 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						have_q <= 1'b0;
						cnt_q  <= '0;
						if (in_ch.command == lpm_pkg::CMD_LOAD || limit_next == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!rd_valid_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dest_q  <= in_ch.dest_addr;
			limit_q <= limit_next;
		end
		rd_idx_s1 <= cnt_q[lpm_pkg::IDX_W-1:0];
		if (hit && better) begin
			best_idx_q     <= rd_idx_s1;
			best_mask_q    <= rd_entry.mask;
			best_gateway_q <= rd_entry.gateway;
			best_iface_q   <= rd_entry.iface;
		end
		if ((state_q == ST_DONE) && out_free) begin
			found_q       <= have_q;
			match_index_q <= have_q ? best_idx_q : '0;
			gateway_q     <= have_q ? best_gateway_q : '0;
			iface_q       <= have_q ? best_iface_q : '0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.found         = found_q;
	assign out_ch.match_index   = match_index_q;
	assign out_ch.next_hop_addr = gateway_q;
	assign out_ch.out_interface = iface_q;

endmodule

/* rtl/lpm_chk.sv */
// Port-level assertions for the route lookup top level, bound to it.
module lpm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          found,
	input logic [5:0]                    match_index,
	input logic [lpm_pkg::ADDR_BITS-1:0] next_hop_addr,
	input logic [lpm_pkg::IFACE_W-1:0]   out_interface
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(match_index) && $stable(next_hop_addr) && $stable(out_interface))
		else $error("Result changed while stalled.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("Result shown with no transaction outstanding.");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_acc |-> pend_q < 2'd2)
		else $error("More than two transactions outstanding.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_index == '0 && next_hop_addr == '0 &&
		out_interface == '0)
		else $error("Miss result carries non-zero fields.");

endmodule

bind ipv4_longest_prefix_route_lookup_unit lpm_chk u_lpm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.found         (out_ch.found),
	.match_index   (out_ch.match_index),
	.next_hop_addr (out_ch.next_hop_addr),
	.out_interface (out_ch.out_interface)
);

/* tb/sv/lpm_route_checker.sv */
// Checker that predicts and compares every route lookup and table load result.
module lpm_route_checker
	import lpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	lpm_in_if                  in_ch,
	lpm_out_if                 out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     match_index;
		logic [ADDR_BITS-1:0] next_hop_addr;
		logic [IFACE_W-1:0]   out_interface;
	} route_result_t;

	lpm_entry_t    route_table [TABLE_DEPTH];
	logic [CNT_W-1:0] scan_count = '0;
	route_result_t routes_due [$];
	int            fail_count = 0;
	int unsigned   results_seen = 0;

	assign mismatches = fail_count;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			route_table[i] = '0;
		end
		outstanding = 0;
	end

	function automatic route_result_t longest_prefix_route(input logic [ADDR_BITS-1:0] dest);
		route_result_t res;
		int unsigned   span;
		int unsigned   best;
		int unsigned   i;
		logic          have;
		res  = '0;
		best = 0;
		have = 1'b0;
		span = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
		for (i = 0; i < span; i++) begin
			if ((dest & route_table[i].mask) == route_table[i].prefix) begin
				if (!have || route_table[best].mask < route_table[i].mask) begin
					best = i;
					have = 1'b1;
				end
			end
		end
		if (have) begin
			res.found         = 1'b1;
			res.match_index   = best[IDX_W-1:0];
			res.next_hop_addr = route_table[best].gateway;
			res.out_interface = route_table[best].iface;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want_v,
		input logic [31:0] got_v);
		$display("result %0d: %s expected %h, got %h", results_seen, what, want_v, got_v);
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk) begin : watch
		route_result_t got;
		route_result_t want;
		lpm_entry_t    loaded;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.found         = out_ch.found;
				got.match_index   = out_ch.match_index;
				got.next_hop_addr = out_ch.next_hop_addr;
				got.out_interface = out_ch.out_interface;
				if (routes_due.size() == 0) begin
					report_mismatch("unrequested transaction, found", '0, got.found);
				end else begin
					want = routes_due.pop_front();
					if (got.found !== want.found)
						report_mismatch("found", want.found, got.found);
					if (got.match_index !== want.match_index)
						report_mismatch("match_index", want.match_index, got.match_index);
					if (got.next_hop_addr !== want.next_hop_addr)
						report_mismatch("next_hop_addr", want.next_hop_addr, got.next_hop_addr);
					if (got.out_interface !== want.out_interface)
						report_mismatch("out_interface", want.out_interface, got.out_interface);
				end
				results_seen++;
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.command == CMD_LOAD) begin
					loaded.prefix   = in_ch.entry_prefix;
					loaded.mask     = in_ch.entry_mask;
					loaded.gateway  = in_ch.entry_next_hop;
					loaded.iface    = in_ch.entry_interface;
					route_table[in_ch.entry_index] = loaded;
					routes_due.push_back('0);
				end else begin
					routes_due.push_back(longest_prefix_route(in_ch.dest_addr));
				end
			end
			if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) begin
				scan_count = pwdata[CNT_W-1:0];
			end
		end
		outstanding <= routes_due.size();
	end

endmodule

/* tb/sv/tb_top.sv */
// Top of the route lookup testbench: clock, reset, stimulus, result sink and verdict.
module tb_top;
	import lpm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES    = 80;
	localparam int PHASE_ITEMS    = 100;
	localparam logic [PADDR_W-1:0] ADDR_ENTRIES_IN_USE = {REG_ENTRIES_IN_USE, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED       = {~REG_ENTRIES_IN_USE, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;
	int                 hold_asks = 0;
	int                 quiet_cycles = 0;
	bit                 sender_calm = 1'b0;
	int unsigned        scan_count = 0;
	logic [ADDR_BITS-1:0] loaded_prefix [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] loaded_mask   [TABLE_DEPTH];

	lpm_in_if  in_ch ();
	lpm_out_if out_ch ();

	ipv4_longest_prefix_route_lookup_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lpm_route_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_sink
		int unsigned hold_left;
		int          holds_served;
		int unsigned taken;
		hold_left    = 0;
		holds_served = 0;
		taken        = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				taken++;
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (holds_served != hold_asks) begin
				holds_served = hold_asks;
				hold_left    = RX_HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (taken >= 400 && taken < 560) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	function automatic logic [ADDR_BITS-1:0] prefix_mask(input int unsigned len);
		return (len == 0) ? '0 : ('1 << (ADDR_BITS - len));
	endfunction

	task automatic offer_request(input logic cmd, input logic [IDX_W-1:0] idx,
		input logic [ADDR_BITS-1:0] pfx, input logic [ADDR_BITS-1:0] msk,
		input logic [ADDR_BITS-1:0] hop, input logic [IFACE_W-1:0] ifc,
		input logic [ADDR_BITS-1:0] dest);
		while (!sender_calm && $urandom_range(99) < 15) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.command         <= cmd;
		in_ch.entry_index     <= idx;
		in_ch.entry_prefix    <= pfx;
		in_ch.entry_mask      <= msk;
		in_ch.entry_next_hop  <= hop;
		in_ch.entry_interface <= ifc;
		in_ch.dest_addr       <= dest;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic load_route(input int unsigned idx, input logic [ADDR_BITS-1:0] pfx,
		input logic [ADDR_BITS-1:0] msk, input logic [ADDR_BITS-1:0] hop,
		input logic [IFACE_W-1:0] ifc);
		loaded_prefix[idx] = pfx;
		loaded_mask[idx]   = msk;
		offer_request(CMD_LOAD, idx[IDX_W-1:0], pfx, msk, hop, ifc, $urandom);
	endtask

	task automatic look_up(input logic [ADDR_BITS-1:0] dest);
		offer_request(CMD_LOOKUP, IDX_W'($urandom_range(TABLE_DEPTH-1)), $urandom, $urandom,
			$urandom, IFACE_W'($urandom_range(15)), dest);
	endtask

	task automatic load_random_route(input int unsigned idx);
		int unsigned          len;
		int unsigned          k;
		logic [ADDR_BITS-1:0] m;
		logic [ADDR_BITS-1:0] base;
		k = $urandom_range(TABLE_DEPTH-1);
		if ($urandom_range(99) < 80) begin
			if ($urandom_range(3) == 0)
				len = 8 * $urandom_range(4);
			else
				len = $urandom_range(32);
			m    = prefix_mask(len);
			base = ($urandom_range(99) < 40) ? loaded_prefix[k] : $urandom;
			load_route(idx, base & m, m, $urandom, IFACE_W'($urandom_range(15)));
		end else begin
			m    = $urandom;
			base = $urandom;
			load_route(idx, $urandom_range(1) ? (base & m) : base, m, $urandom,
				IFACE_W'($urandom_range(15)));
		end
	endtask

	task automatic look_up_random(input int unsigned scan);
		int unsigned          span;
		int unsigned          k;
		int unsigned          pick;
		logic [ADDR_BITS-1:0] dest;
		span = (scan > TABLE_DEPTH) ? TABLE_DEPTH : scan;
		pick = $urandom_range(99);
		if (span != 0 && pick < 75) begin
			k    = $urandom_range(span - 1);
			dest = (loaded_prefix[k] & loaded_mask[k]) | ($urandom & ~loaded_mask[k]);
		end else if (pick < 85) begin
			dest = pick[0] ? '1 : '0;
		end else begin
			dest = $urandom;
		end
		look_up(dest);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_ENTRIES_IN_USE)
			scan_count = data[CNT_W-1:0];
	endtask

	initial begin : stimulus
		int unsigned fill_order [TABLE_DEPTH];
		int unsigned scan_plan [8];
		int unsigned tmp;
		int unsigned j;
		int          p;
		int          n;
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		in_ch.valid           <= 1'b0;
		in_ch.command         <= CMD_LOAD;
		in_ch.entry_index     <= '0;
		in_ch.entry_prefix    <= '0;
		in_ch.entry_mask      <= '0;
		in_ch.entry_next_hop  <= '0;
		in_ch.entry_interface <= '0;
		in_ch.dest_addr       <= '0;
		for (p = 0; p < TABLE_DEPTH; p++) begin
			loaded_prefix[p] = '0;
			loaded_mask[p]   = '0;
			fill_order[p]    = p;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With an empty scan range nothing can match.
		write_reg(ADDR_ENTRIES_IN_USE, 0);
		look_up('0);
		look_up('1);
		load_route(0, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 4'd1);
		load_route(1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 4'd2);
		load_route(2, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_01FE, 4'd3);
		load_route(3, 32'hC0A8_0105, 32'hFFFF_FFFF, 32'hC0A8_0105, 4'd4);
		load_route(4, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hDEAD_0004, 4'd5);
		load_route(5, 32'h0A00_0B00, 32'hFF00_FF00, 32'h0A0B_0C0D, 4'd6);
		load_route(6, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
		load_route(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		load_route(63, 32'hAC10_0000, 32'hFFF0_0000, 32'h1234_5678, 4'd0);
		wait_drained();
		write_reg(ADDR_ENTRIES_IN_USE, 8);
		// A write outside the register map must leave the scan range alone.
		write_reg(ADDR_UNMAPPED, 0);
		look_up(32'hC0A8_0105);
		look_up(32'hC0A8_0109);
		look_up(32'hC0A8_0201);
		look_up(32'h0A7F_0B33);
		look_up(32'h0808_0808);
		look_up('1);
		look_up('0);

		// Fill every table entry in random order before wider scans are enabled.
		for (p = TABLE_DEPTH - 1; p > 0; p--) begin
			j             = $urandom_range(p);
			tmp           = fill_order[p];
			fill_order[p] = fill_order[j];
			fill_order[j] = tmp;
		end
		for (p = 0; p < TABLE_DEPTH; p++) begin
			load_random_route(fill_order[p]);
			if ($urandom_range(1) == 1)
				look_up_random(scan_count);
		end

		scan_plan = '{64, 127, 1, 0, 0, 64, 0, 64};
		scan_plan[3] = $urandom_range(63, 2);
		scan_plan[6] = $urandom_range(126, 65);
		for (p = 0; p < 8; p++) begin
			wait_drained();
			write_reg(ADDR_ENTRIES_IN_USE, scan_plan[p]);
			sender_calm = (p == 5);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == PHASE_ITEMS / 2)
					hold_asks <= hold_asks + 1;
				if (p == 2 && n == PHASE_ITEMS / 2)
					wait_drained();
				if ($urandom_range(99) < 30)
					load_random_route($urandom_range(TABLE_DEPTH - 1));
				else
					look_up_random(scan_count);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/lpm_pkg.sv
rtl/lpm_if.sv
rtl/lpm_ram.sv
rtl/ipv4_longest_prefix_route_lookup_unit.sv
rtl/lpm_chk.sv
tb/sv/lpm_route_checker.sv
tb/sv/tb_top.sv
